/* design/jsu_pkg.sv */
package jsu_pkg;

   // Error codes carried on each result
   typedef enum logic [2:0] {
      ERR_NONE          = 3'd0,
      ERR_MISSING_QUOTE = 3'd1,
      ERR_CONTROL_CHAR  = 3'd2,
      ERR_BAD_ESCAPE    = 3'd3,
      ERR_BAD_HEX       = 3'd4,
      ERR_BAD_SURROGATE = 3'd5
   } err_type;

   // Most result bytes one input byte can cause (a four-byte UTF-8 sequence)
   localparam int unsigned MAX_RUN = 4;

   // Default depth of the run queue between decoder and emitter
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // One run: every result caused by a single input item
   typedef struct packed {
      logic [MAX_RUN-1:0][7:0]       bytes;
      logic [$clog2(MAX_RUN)-1:0]    last_idx;
      logic                          byte_valid;
      logic                          string_done;
      err_type                       error_code;
   } run_type;

endpackage

/* design/jsu_front.sv */
module jsu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_new_string,
   input  logic              queue_full,
   output logic              push,
   output jsu_pkg::run_type  push_run
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BODY,
      PH_ESC,
      PH_HEX1,
      PH_WANTBS,
      PH_WANTU,
      PH_HEX2
   } phase_type;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   // Return {ok, value} for one ASCII hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Split one code point into its UTF-8 bytes
   function automatic jsu_pkg::run_type utf8_encode(input logic [20:0] u);
      jsu_pkg::run_type r;
      r = '0;
      r.byte_valid = 1'b1;
      r.error_code = jsu_pkg::ERR_NONE;
      if (u <= 21'h7F) begin
         r.bytes[0] = u[7:0];
         r.last_idx = 2'd0;
      end else if (u <= 21'h7FF) begin
         r.bytes[0] = {3'b110, u[10:6]};
         r.bytes[1] = {2'b10, u[5:0]};
         r.last_idx = 2'd1;
      end else if (u <= 21'hFFFF) begin
         r.bytes[0] = {4'b1110, u[15:12]};
         r.bytes[1] = {2'b10, u[11:6]};
         r.bytes[2] = {2'b10, u[5:0]};
         r.last_idx = 2'd2;
      end else begin
         r.bytes[0] = {5'b11110, u[20:18]};
         r.bytes[1] = {2'b10, u[17:12]};
         r.bytes[2] = {2'b10, u[11:6]};
         r.bytes[3] = {2'b10, u[5:0]};
         r.last_idx = 2'd3;
      end
      return r;
   endfunction

   phase_type        phase_ff, phase_in;
   logic [15:0]      accum_ff, accum_in;
   logic [15:0]      high_ff, high_in;
   logic [1:0]       count_ff, count_in;

   phase_type        cur_phase;
   logic [15:0]      cur_accum;
   logic [15:0]      cur_high;
   logic [1:0]       cur_count;
   logic [4:0]       hex;
   logic [15:0]      accum_shift;
   logic [20:0]      pair_cp;
   logic             emit;
   jsu_pkg::run_type run;
   logic             accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && emit;
   assign push_run  = run;

   // Decode one byte against the current phase
   always_comb begin
      cur_phase   = req_new_string ? PH_BODY : phase_ff;
      cur_accum   = req_new_string ? 16'd0 : accum_ff;
      cur_high    = req_new_string ? 16'd0 : high_ff;
      cur_count   = req_new_string ? 2'd0 : count_ff;
      hex         = hex_value(req_in_byte);
      accum_shift = {cur_accum[11:0], hex[3:0]};
      pair_cp     = {1'b0, cur_high[9:0], accum_shift[9:0]} + 21'h10000;

      phase_in = cur_phase;
      accum_in = cur_accum;
      high_in  = cur_high;
      count_in = cur_count;
      emit     = 1'b0;
      run      = '0;
      run.error_code = jsu_pkg::ERR_NONE;

      case (cur_phase)
         PH_BODY: begin
            if (req_in_byte == CH_QUOTE) begin
               phase_in = PH_IDLE;
               emit = 1'b1;
               run.string_done = 1'b1;
            end else if (req_in_byte == CH_NUL) begin
               phase_in = PH_IDLE;
               emit = 1'b1;
               run.error_code = jsu_pkg::ERR_MISSING_QUOTE;
            end else if (req_in_byte == CH_BACKSLASH) begin
               phase_in = PH_ESC;
            end else if (req_in_byte < CH_SPACE) begin
               phase_in = PH_IDLE;
               emit = 1'b1;
               run.error_code = jsu_pkg::ERR_CONTROL_CHAR;
            end else begin
               emit = 1'b1;
               run.byte_valid = 1'b1;
               run.bytes[0] = req_in_byte;
            end
         end
         PH_ESC: begin
            phase_in = PH_BODY;
            emit = 1'b1;
            run.byte_valid = 1'b1;
            case (req_in_byte)
               CH_QUOTE:     run.bytes[0] = CH_QUOTE;
               CH_BACKSLASH: run.bytes[0] = CH_BACKSLASH;
               CH_SLASH:     run.bytes[0] = CH_SLASH;
               CH_B:         run.bytes[0] = 8'h08;
               CH_F:         run.bytes[0] = 8'h0C;
               CH_N:         run.bytes[0] = 8'h0A;
               CH_T:         run.bytes[0] = 8'h09;
               CH_R:         run.bytes[0] = 8'h0D;
               CH_U: begin
                  phase_in = PH_HEX1;
                  accum_in = 16'd0;
                  count_in = 2'd0;
                  emit = 1'b0;
                  run.byte_valid = 1'b0;
               end
               default: begin
                  phase_in = PH_IDLE;
                  run.byte_valid = 1'b0;
                  run.error_code = jsu_pkg::ERR_BAD_ESCAPE;
               end
            endcase
         end
         PH_HEX1, PH_HEX2: begin
            if (!hex[4]) begin
               phase_in = PH_IDLE;
               emit = 1'b1;
               run.error_code = jsu_pkg::ERR_BAD_HEX;
            end else begin
               accum_in = accum_shift;
               count_in = cur_count + 2'd1;
               // Fourth digit closes the group
               if (cur_count == 2'd3) begin
                  if (cur_phase == PH_HEX1) begin
                     if (accum_shift inside {[16'hD800:16'hDBFF]}) begin
                        high_in  = accum_shift;
                        phase_in = PH_WANTBS;
                     end else begin
                        phase_in = PH_BODY;
                        emit = 1'b1;
                        run = utf8_encode({5'd0, accum_shift});
                     end
                  end else if (!(accum_shift inside {[16'hDC00:16'hDFFF]})) begin
                     phase_in = PH_IDLE;
                     emit = 1'b1;
                     run.error_code = jsu_pkg::ERR_BAD_SURROGATE;
                  end else begin
                     phase_in = PH_BODY;
                     emit = 1'b1;
                     run = utf8_encode(pair_cp);
                  end
               end
            end
         end
         PH_WANTBS: begin
            if (req_in_byte == CH_BACKSLASH) begin
               phase_in = PH_WANTU;
            end else begin
               phase_in = PH_IDLE;
               emit = 1'b1;
               run.error_code = jsu_pkg::ERR_BAD_SURROGATE;
            end
         end
         PH_WANTU: begin
            if (req_in_byte == CH_U) begin
               phase_in = PH_HEX2;
               accum_in = 16'd0;
               count_in = 2'd0;
            end else begin
               phase_in = PH_IDLE;
               emit = 1'b1;
               run.error_code = jsu_pkg::ERR_BAD_SURROGATE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Advance decode state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         accum_ff <= 16'd0;
         high_ff  <= 16'd0;
         count_ff <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         high_ff  <= high_in;
         count_ff <= count_in;
      end
   end

endmodule

/* design/jsu_queue.sv */
module jsu_queue #(
   parameter int unsigned Depth = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jsu_pkg::run_type  push_run,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output jsu_pkg::run_type  head_run
);

   localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] DepthCnt = CountWidth'(Depth);

   jsu_pkg::run_type        slot_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   assign full     = (count_ff == DepthCnt);
   assign empty    = (count_ff == '0);
   assign head_run = slot_ff[rd_ptr_ff];

   // Wrap pointers and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed runs
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_run;
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("run pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("run popped from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill level lost a push");
`endif

endmodule

/* design/jsu_back.sv */
module jsu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  jsu_pkg::run_type  head_run,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_string_done,
   output logic [2:0]        rsp_error_code,
   output logic              rsp_last_of_run
);

   jsu_pkg::run_type  run_ff, run_in;
   logic [1:0]        pos_ff, pos_in;
   logic              busy_ff, busy_in;
   logic              at_last;
   logic              load;

   assign at_last = (pos_ff == run_ff.last_idx);
   assign load    = !busy_ff || (rsp_ready && at_last);
   assign pop     = load && !queue_empty;

   assign rsp_valid       = busy_ff;
   assign rsp_out_byte    = run_ff.bytes[pos_ff];
   assign rsp_byte_valid  = run_ff.byte_valid;
   assign rsp_string_done = run_ff.string_done;
   assign rsp_error_code  = run_ff.error_code;
   assign rsp_last_of_run = at_last;

   // Step through the bytes of the current run, fetch the next at its end
   always_comb begin
      run_in  = run_ff;
      pos_in  = pos_ff;
      busy_in = busy_ff;
      if (load) begin
         busy_in = !queue_empty;
         pos_in  = 2'd0;
         if (!queue_empty) begin
            run_in = head_run;
         end
      end else if (rsp_ready) begin
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
      run_ff <= run_in;
   end

`ifndef SYNTH
   a_pos_in_run: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff <= run_ff.last_idx))
      else $error("byte index ran past end of run");
   a_single_flag_run: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !run_ff.byte_valid) |-> (run_ff.last_idx == 2'd0))
      else $error("status result spans more than one beat");
`endif

endmodule

/* design/json_string_unescape_utf8_core.sv */
// With the output idle, the first result of an input item is offered on rsp_valid once the
// accepted item has been written into the queue and then loaded into the output stage.
// Throughput: one input item per cycle; each input causes up to four results (UTF-8 bytes),
// and a run queue of QueueDepth entries absorbs bursts.
// Input stalls only when that queue is full.
// Reset (synchronous, active high) idles the decoder and empties the queue and output stage.
module json_string_unescape_utf8_core #(
   parameter int unsigned QueueDepth = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_new_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_string_done,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_of_run
);

   logic              push;
   logic              pop;
   logic              full;
   logic              empty;
   jsu_pkg::run_type  push_run;
   jsu_pkg::run_type  head_run;

   jsu_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_new_string (req_new_string),
      .queue_full     (full),
      .push           (push),
      .push_run       (push_run)
   );

   jsu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head_run (head_run)
   );

   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (empty),
      .head_run        (head_run),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_string_done (rsp_string_done),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
